// ===== rtl/nug_pkg.sv =====
package nug_pkg;

    localparam int TIME_BITS = 48;
    localparam int SENSOR_COUNT = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [TIME_BITS-1:0] time_t;

    // sensor slots in the seen-timestamp table
    localparam int SENS_ACCEL = 0;
    localparam int SENS_MAG = 1;
    localparam int SENS_GPS = 2;
    localparam int SENS_BARO = 3;
    localparam int SENS_STATIC = 4;
    localparam int SENS_DYNAMIC = 5;

    localparam logic [7:0] MAG_COUNT_MAX = '1;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_CALIBRATE   = 3'd1,
        CMD_CALIB_DONE  = 3'd2,
        CMD_FORCE_START = 3'd3,
        CMD_ARMED       = 3'd4,
        CMD_LANDED      = 3'd5,
        CMD_FORCE_STOP  = 3'd6,
        CMD_DISARMED    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_CALIB  = 3'd1,
        MODE_READY  = 3'd2,
        MODE_ACTIVE = 3'd3,
        MODE_END    = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAG_DECIMATE      = 3'd0,
        CFG_GPS_ACCEL_LIMIT   = 3'd1,
        CFG_ONE_G_LOW         = 3'd2,
        CFG_ONE_G_HIGH        = 3'd3,
        CFG_ONE_G_SAMPLES     = 3'd4,
        CFG_PITOT_ALT_LIMIT   = 3'd5,
        CFG_PITOT_SPEED_LIMIT = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]         mag_decimate;
        logic [31:0]        gps_accel_limit_sq;
        logic [31:0]        one_g_low_sq;
        logic [31:0]        one_g_high_sq;
        logic [15:0]        one_g_samples;
        logic signed [31:0] pitot_alt_limit;
        logic signed [31:0] pitot_speed_limit;
    } cfg_t;

    typedef struct packed {
        logic run_predict;
        logic run_mag;
        logic run_gps;
        logic run_baro;
        logic run_pitot;
        logic run_accel;
        logic one_g_ok;
    } gate_res_t;

endpackage

// ===== rtl/nav_update_gate_fsm.sv =====
// Mode controller and correction gate for a navigation filter. Each request
// carries an event code or a tick plus sensor timestamps and filter state; each
// request yields exactly one result with the mode after the request and the
// correction strobes. A request goes through an input register and a result
// register; it moves on to the result register unless a result is waiting
// with out_ready low, and out_valid rises when it does. One request per
// cycle is sustained as long as out_ready stays high. The mode is updated
// as a request moves on to the result register, and the decimation counter,
// one-g qualifier and seen timestamps too when it is a tick in active mode.
// Configuration writes take effect on the next cycle and must only be issued
// while no request is in flight.
module nav_update_gate_fsm
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [nug_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [nug_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          cmd,
    input  logic [31:0]                         accel_norm_sq,
    input  logic [nug_pkg::TIME_BITS-1:0]       accel_time,
    input  logic [nug_pkg::TIME_BITS-1:0]       mag_time,
    input  logic [nug_pkg::TIME_BITS-1:0]       gps_time,
    input  logic [nug_pkg::TIME_BITS-1:0]       baro_time,
    input  logic [nug_pkg::TIME_BITS-1:0]       static_time,
    input  logic [nug_pkg::TIME_BITS-1:0]       dynamic_time,
    input  logic                                gps_fix_3d,
    input  logic signed [31:0]                  dynamic_pressure,
    input  logic signed [31:0]                  down_position,
    input  logic signed [31:0]                  down_velocity,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          mode,
    output logic                                run_predict,
    output logic                                run_mag,
    output logic                                run_gps,
    output logic                                run_baro,
    output logic                                run_pitot,
    output logic                                run_accel,
    output logic                                one_g_ok
);

    nug_pkg::cfg_t       cfg_reg;

    logic                in_valid_reg;
    nug_pkg::cmd_t       cmd_reg;
    logic [31:0]         accel_norm_sq_reg;
    nug_pkg::time_t      times_reg [nug_pkg::SENSOR_COUNT];
    logic                gps_fix_3d_reg;
    logic signed [31:0]  dynamic_pressure_reg;
    logic signed [31:0]  down_position_reg;
    logic signed [31:0]  down_velocity_reg;

    logic                out_valid_reg;
    nug_pkg::mode_t      mode_out_reg;
    nug_pkg::gate_res_t  res_out_reg;

    logic                step;
    logic                active;
    logic                tick;
    nug_pkg::mode_t      mode_after;
    nug_pkg::gate_res_t  res;

    // request moves from input register to result register
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign tick     = active && (cmd_reg == nug_pkg::CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nug_pkg::CFG_MAG_DECIMATE:
                    cfg_reg.mag_decimate <= cfg_data[7:0];
                nug_pkg::CFG_GPS_ACCEL_LIMIT:
                    cfg_reg.gps_accel_limit_sq <= cfg_data[31:0];
                nug_pkg::CFG_ONE_G_LOW:
                    cfg_reg.one_g_low_sq <= cfg_data[31:0];
                nug_pkg::CFG_ONE_G_HIGH:
                    cfg_reg.one_g_high_sq <= cfg_data[31:0];
                nug_pkg::CFG_ONE_G_SAMPLES:
                    cfg_reg.one_g_samples <= cfg_data[15:0];
                nug_pkg::CFG_PITOT_ALT_LIMIT:
                    cfg_reg.pitot_alt_limit <= cfg_data[31:0];
                nug_pkg::CFG_PITOT_SPEED_LIMIT:
                    cfg_reg.pitot_speed_limit <= cfg_data[31:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg                              <= nug_pkg::cmd_t'(cmd);
            accel_norm_sq_reg                    <= accel_norm_sq;
            times_reg[nug_pkg::SENS_ACCEL]       <= accel_time;
            times_reg[nug_pkg::SENS_MAG]         <= mag_time;
            times_reg[nug_pkg::SENS_GPS]         <= gps_time;
            times_reg[nug_pkg::SENS_BARO]        <= baro_time;
            times_reg[nug_pkg::SENS_STATIC]      <= static_time;
            times_reg[nug_pkg::SENS_DYNAMIC]     <= dynamic_time;
            gps_fix_3d_reg                       <= gps_fix_3d;
            dynamic_pressure_reg                 <= dynamic_pressure;
            down_position_reg                    <= down_position;
            down_velocity_reg                    <= down_velocity;
        end
        if (step)
        begin
            mode_out_reg <= mode_after;
            res_out_reg  <= res;
        end
    end

    nug_mode_fsm u_mode_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd        (cmd_reg),
        .mode_after (mode_after),
        .active     (active)
    );

    nug_gate u_gate
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .tick             (tick),
        .cfg              (cfg_reg),
        .accel_norm_sq    (accel_norm_sq_reg),
        .times            (times_reg),
        .gps_fix_3d       (gps_fix_3d_reg),
        .dynamic_pressure (dynamic_pressure_reg),
        .down_position    (down_position_reg),
        .down_velocity    (down_velocity_reg),
        .res              (res)
    );

    assign out_valid   = out_valid_reg;
    assign mode        = mode_out_reg;
    assign run_predict = res_out_reg.run_predict;
    assign run_mag     = res_out_reg.run_mag;
    assign run_gps     = res_out_reg.run_gps;
    assign run_baro    = res_out_reg.run_baro;
    assign run_pitot   = res_out_reg.run_pitot;
    assign run_accel   = res_out_reg.run_accel;
    assign one_g_ok    = res_out_reg.one_g_ok;

endmodule

// ===== rtl/nug_mode_fsm.sv =====
module nug_mode_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  nug_pkg::cmd_t     cmd,
    output nug_pkg::mode_t    mode_after,
    output logic              active
);

    nug_pkg::mode_t mode_reg;
    nug_pkg::mode_t mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= nug_pkg::MODE_INIT;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        unique case (cmd)
            nug_pkg::CMD_CALIBRATE:
            begin
                if (mode_reg == nug_pkg::MODE_INIT || mode_reg == nug_pkg::MODE_READY)
                begin
                    mode_next = nug_pkg::MODE_CALIB;
                end
            end
            nug_pkg::CMD_CALIB_DONE:
            begin
                if (mode_reg == nug_pkg::MODE_CALIB)
                begin
                    mode_next = nug_pkg::MODE_READY;
                end
            end
            nug_pkg::CMD_FORCE_START, nug_pkg::CMD_ARMED:
            begin
                if (mode_reg == nug_pkg::MODE_READY)
                begin
                    mode_next = nug_pkg::MODE_ACTIVE;
                end
            end
            nug_pkg::CMD_LANDED:
            begin
                if (mode_reg == nug_pkg::MODE_ACTIVE)
                begin
                    mode_next = nug_pkg::MODE_END;
                end
            end
            nug_pkg::CMD_FORCE_STOP, nug_pkg::CMD_DISARMED:
            begin
                if (mode_reg == nug_pkg::MODE_ACTIVE)
                begin
                    mode_next = nug_pkg::MODE_READY;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb
    begin
        mode_after = mode_next;
        active     = (mode_reg == nug_pkg::MODE_ACTIVE);
    end

endmodule

// ===== rtl/nug_gate.sv =====
module nug_gate
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                tick,
    input  nug_pkg::cfg_t       cfg,
    input  logic [31:0]         accel_norm_sq,
    input  nug_pkg::time_t      times [nug_pkg::SENSOR_COUNT],
    input  logic                gps_fix_3d,
    input  logic signed [31:0]  dynamic_pressure,
    input  logic signed [31:0]  down_position,
    input  logic signed [31:0]  down_velocity,
    output nug_pkg::gate_res_t  res
);

    nug_pkg::time_t seen_reg [nug_pkg::SENSOR_COUNT];
    logic [7:0]     mag_count_reg;
    logic [7:0]     mag_count_next;
    logic [15:0]    one_g_count_reg;
    logic [15:0]    one_g_count_next;
    logic           one_g_flag_reg;
    logic           one_g_flag_next;

    logic [nug_pkg::SENSOR_COUNT-1:0] fresh;
    logic signed [32:0] up_position;
    logic signed [32:0] up_velocity;
    logic               alt_ok;
    logic               speed_ok;
    logic               in_band;
    logic               mag_fire;

    always_comb
    begin
        for (int i = 0; i < nug_pkg::SENSOR_COUNT; i++)
        begin
            fresh[i] = seen_reg[i] < times[i];
        end
    end

    // 33-bit negation so the most negative input does not wrap
    assign up_position = -{down_position[31], down_position};
    assign up_velocity = -{down_velocity[31], down_velocity};
    assign alt_ok   = up_position < $signed({cfg.pitot_alt_limit[31], cfg.pitot_alt_limit});
    assign speed_ok = up_velocity > $signed({cfg.pitot_speed_limit[31], cfg.pitot_speed_limit});

    assign in_band  = (accel_norm_sq < cfg.one_g_high_sq) && (accel_norm_sq > cfg.one_g_low_sq);
    assign mag_fire = fresh[nug_pkg::SENS_MAG] && (mag_count_reg >= cfg.mag_decimate);

    always_comb
    begin
        mag_count_next   = mag_count_reg;
        one_g_count_next = one_g_count_reg;
        one_g_flag_next  = one_g_flag_reg;
        if (tick)
        begin
            if (mag_fire)
            begin
                mag_count_next = '0;
            end
            else if (mag_count_reg < nug_pkg::MAG_COUNT_MAX)
            begin
                mag_count_next = mag_count_reg + 8'd1;
            end

            if (in_band)
            begin
                if (one_g_count_reg < cfg.one_g_samples)
                begin
                    one_g_count_next = one_g_count_reg + 16'd1;
                end
                else
                begin
                    one_g_flag_next = 1'b1;
                end
            end
            else
            begin
                one_g_count_next = '0;
                one_g_flag_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        res             = '0;
        res.one_g_ok    = one_g_flag_next;
        if (tick)
        begin
            res.run_predict = 1'b1;
            res.run_mag     = mag_fire;
            res.run_gps     = fresh[nug_pkg::SENS_GPS] && gps_fix_3d
                              && (accel_norm_sq < cfg.gps_accel_limit_sq);
            res.run_baro    = fresh[nug_pkg::SENS_BARO];
            res.run_pitot   = (dynamic_pressure > 32'sd0)
                              && (fresh[nug_pkg::SENS_STATIC] || fresh[nug_pkg::SENS_DYNAMIC])
                              && alt_ok && speed_ok;
            // uses the flag from before this tick
            res.run_accel   = fresh[nug_pkg::SENS_ACCEL] && one_g_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nug_pkg::SENSOR_COUNT; i++)
            begin
                seen_reg[i] <= '0;
            end
            mag_count_reg   <= '0;
            one_g_count_reg <= '0;
            one_g_flag_reg  <= 1'b0;
        end
        else if (step && tick)
        begin
            for (int i = 0; i < nug_pkg::SENSOR_COUNT; i++)
            begin
                seen_reg[i] <= times[i];
            end
            mag_count_reg   <= mag_count_next;
            one_g_count_reg <= one_g_count_next;
            one_g_flag_reg  <= one_g_flag_next;
        end
    end

endmodule

// ===== tb/sv/nug_tb_pkg.sv =====
`timescale 1ns / 1ps

package nug_tb_pkg;

    import nug_pkg::*;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [31:0]        accel_norm_sq;
        time_t              accel_time;
        time_t              mag_time;
        time_t              gps_time;
        time_t              baro_time;
        time_t              static_time;
        time_t              dynamic_time;
        logic               gps_fix_3d;
        logic signed [31:0] dynamic_pressure;
        logic signed [31:0] down_position;
        logic signed [31:0] down_velocity;
    } nav_req_t;

    typedef struct packed {
        logic [2:0] mode;
        gate_res_t  gate;
    } gate_decision_t;

    class gate_decision_board;
        logic [7:0]  mag_decimate;
        logic [31:0] gps_accel_limit_sq;
        logic [31:0] one_g_low_sq;
        logic [31:0] one_g_high_sq;
        logic [15:0] one_g_samples;
        longint      pitot_alt_limit;
        longint      pitot_speed_limit;

        mode_t       mode_q;
        logic [7:0]  mag_skip_count;
        time_t       seen_time [SENSOR_COUNT];
        logic [15:0] one_g_count;
        logic        one_g_flag;

        gate_decision_t pending_decisions [$];
        int unsigned    mismatch_count;

        function new();
            mag_decimate       = '0;
            gps_accel_limit_sq = '0;
            one_g_low_sq       = '0;
            one_g_high_sq      = '0;
            one_g_samples      = '0;
            pitot_alt_limit    = 0;
            pitot_speed_limit  = 0;
            mode_q             = MODE_INIT;
            mag_skip_count     = '0;
            foreach (seen_time[i]) seen_time[i] = '0;
            one_g_count        = '0;
            one_g_flag         = 1'b0;
            mismatch_count     = 0;
        endfunction

        function void set_config(cfg_index_t index, logic [31:0] value);
            case (index)
                CFG_MAG_DECIMATE:      mag_decimate = value[7:0];
                CFG_GPS_ACCEL_LIMIT:   gps_accel_limit_sq = value;
                CFG_ONE_G_LOW:         one_g_low_sq = value;
                CFG_ONE_G_HIGH:        one_g_high_sq = value;
                CFG_ONE_G_SAMPLES:     one_g_samples = value[15:0];
                CFG_PITOT_ALT_LIMIT:   pitot_alt_limit = longint'($signed(value));
                CFG_PITOT_SPEED_LIMIT: pitot_speed_limit = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function void note_request(nav_req_t r);
            gate_decision_t want;
            time_t          stamp [SENSOR_COUNT];
            logic           fresh [SENSOR_COUNT];
            want = '0;
            case (cmd_t'(r.cmd))
                CMD_CALIBRATE:
                    if (mode_q == MODE_INIT || mode_q == MODE_READY) mode_q = MODE_CALIB;
                CMD_CALIB_DONE:
                    if (mode_q == MODE_CALIB) mode_q = MODE_READY;
                CMD_FORCE_START, CMD_ARMED:
                    if (mode_q == MODE_READY) mode_q = MODE_ACTIVE;
                CMD_LANDED:
                    if (mode_q == MODE_ACTIVE) mode_q = MODE_END;
                CMD_FORCE_STOP, CMD_DISARMED:
                    if (mode_q == MODE_ACTIVE) mode_q = MODE_READY;
                default:
                    if (mode_q == MODE_ACTIVE)
                    begin
                        stamp[SENS_ACCEL]   = r.accel_time;
                        stamp[SENS_MAG]     = r.mag_time;
                        stamp[SENS_GPS]     = r.gps_time;
                        stamp[SENS_BARO]    = r.baro_time;
                        stamp[SENS_STATIC]  = r.static_time;
                        stamp[SENS_DYNAMIC] = r.dynamic_time;
                        foreach (stamp[i]) fresh[i] = seen_time[i] < stamp[i];

                        want.gate.run_predict = 1'b1;

                        if (fresh[SENS_MAG] && mag_skip_count >= mag_decimate)
                        begin
                            want.gate.run_mag = 1'b1;
                            mag_skip_count = '0;
                        end
                        else if (mag_skip_count != MAG_COUNT_MAX)
                        begin
                            mag_skip_count++;
                        end

                        want.gate.run_gps = fresh[SENS_GPS] && r.gps_fix_3d
                                            && (r.accel_norm_sq < gps_accel_limit_sq);
                        want.gate.run_baro = fresh[SENS_BARO];
                        // windows in 64 bits so negating the most negative value is exact
                        want.gate.run_pitot = ($signed(r.dynamic_pressure) > 32'sd0)
                            && (fresh[SENS_STATIC] || fresh[SENS_DYNAMIC])
                            && (-longint'($signed(r.down_position)) < pitot_alt_limit)
                            && (-longint'($signed(r.down_velocity)) > pitot_speed_limit);
                        // gate uses the flag from before this tick
                        want.gate.run_accel = fresh[SENS_ACCEL] && one_g_flag;

                        if (r.accel_norm_sq < one_g_high_sq && r.accel_norm_sq > one_g_low_sq)
                        begin
                            if (one_g_count < one_g_samples) one_g_count++;
                            else one_g_flag = 1'b1;
                        end
                        else
                        begin
                            one_g_count = '0;
                            one_g_flag  = 1'b0;
                        end

                        foreach (stamp[i]) seen_time[i] = stamp[i];
                    end
            endcase
            want.mode          = mode_q;
            want.gate.one_g_ok = one_g_flag;
            pending_decisions.push_back(want);
        endfunction

        function void compare_field(string field, logic [2:0] want, logic [2:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_decision(gate_decision_t got);
            gate_decision_t want;
            if (pending_decisions.size() == 0)
            begin
                $error("result with no request waiting: mode %0d", got.mode);
                mismatch_count++;
                return;
            end
            want = pending_decisions.pop_front();
            compare_field("mode", want.mode, got.mode);
            compare_field("run_predict", want.gate.run_predict, got.gate.run_predict);
            compare_field("run_mag", want.gate.run_mag, got.gate.run_mag);
            compare_field("run_gps", want.gate.run_gps, got.gate.run_gps);
            compare_field("run_baro", want.gate.run_baro, got.gate.run_baro);
            compare_field("run_pitot", want.gate.run_pitot, got.gate.run_pitot);
            compare_field("run_accel", want.gate.run_accel, got.gate.run_accel);
            compare_field("one_g_ok", want.gate.one_g_ok, got.gate.one_g_ok);
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_nav_update_gate_fsm.sv =====
`timescale 1ns / 1ps

module tb_nav_update_gate_fsm;

    import nug_pkg::*;
    import nug_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned HOLD_OFF_CYCLES = 64;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    nav_req_t                  req_bus;
    logic                      out_valid;
    logic                      out_ready;
    logic [2:0]                mode;
    logic                      run_predict;
    logic                      run_mag;
    logic                      run_gps;
    logic                      run_baro;
    logic                      run_pitot;
    logic                      run_accel;
    logic                      one_g_ok;

    gate_decision_board sb;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    logic               hold_off_req;
    int unsigned        cycle_count = 0;

    nav_update_gate_fsm u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (req_bus.cmd),
        .accel_norm_sq    (req_bus.accel_norm_sq),
        .accel_time       (req_bus.accel_time),
        .mag_time         (req_bus.mag_time),
        .gps_time         (req_bus.gps_time),
        .baro_time        (req_bus.baro_time),
        .static_time      (req_bus.static_time),
        .dynamic_time     (req_bus.dynamic_time),
        .gps_fix_3d       (req_bus.gps_fix_3d),
        .dynamic_pressure (req_bus.dynamic_pressure),
        .down_position    (req_bus.down_position),
        .down_velocity    (req_bus.down_velocity),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mode             (mode),
        .run_predict      (run_predict),
        .run_mag          (run_mag),
        .run_gps          (run_gps),
        .run_baro         (run_baro),
        .run_pitot        (run_pitot),
        .run_accel        (run_accel),
        .one_g_ok         (one_g_ok)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_decision(gate_decision_t'({mode, run_predict, run_mag, run_gps, run_baro,
                                                run_pitot, run_accel, one_g_ok}));
    end

    // result side: random stalls, or a long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // mostly newer than the last seen stamp, sometimes equal, older or wild
    function automatic time_t next_stamp(time_t prev);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return prev + time_t'($urandom_range(1, 5000));
            5, 6: return prev;
            7: return prev - time_t'($urandom_range(0, 50));
            8: return time_t'({$urandom, $urandom});
            default: return ($urandom_range(1) != 0) ? {TIME_BITS{1'b1}} : '0;
        endcase
    endfunction

    function automatic nav_req_t quiet_tick(time_t stamp);
        nav_req_t r;
        r = '0;
        r.cmd          = CMD_TICK;
        r.accel_time   = stamp;
        r.mag_time     = stamp;
        r.gps_time     = stamp;
        r.baro_time    = stamp;
        r.static_time  = stamp;
        r.dynamic_time = stamp;
        return r;
    endfunction

    function automatic nav_req_t random_request(cmd_t c);
        nav_req_t r;
        r.cmd          = c;
        r.accel_time   = next_stamp(sb.seen_time[SENS_ACCEL]);
        r.mag_time     = next_stamp(sb.seen_time[SENS_MAG]);
        r.gps_time     = next_stamp(sb.seen_time[SENS_GPS]);
        r.baro_time    = next_stamp(sb.seen_time[SENS_BARO]);
        r.static_time  = next_stamp(sb.seen_time[SENS_STATIC]);
        r.dynamic_time = next_stamp(sb.seen_time[SENS_DYNAMIC]);
        r.gps_fix_3d   = ($urandom_range(3) != 0);

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
                if (sb.one_g_high_sq > sb.one_g_low_sq && sb.one_g_high_sq - sb.one_g_low_sq > 1)
                    r.accel_norm_sq = $urandom_range(sb.one_g_high_sq - 1, sb.one_g_low_sq + 1);
                else
                    r.accel_norm_sq = $urandom;
            6, 7: r.accel_norm_sq = $urandom;
            8:
                case ($urandom_range(2))
                    0: r.accel_norm_sq = sb.one_g_low_sq;
                    1: r.accel_norm_sq = sb.one_g_high_sq;
                    default: r.accel_norm_sq = sb.gps_accel_limit_sq;
                endcase
            default: r.accel_norm_sq = extreme_word();
        endcase

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: r.dynamic_pressure = $urandom_range(1, 100000);
            7, 8: r.dynamic_pressure = $urandom;
            default: r.dynamic_pressure = extreme_word();
        endcase

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: r.down_position = -int'($urandom_range(0, 512000));
            6, 7: r.down_position = $urandom;
            default: r.down_position = extreme_word();
        endcase

        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: r.down_velocity = int'($urandom_range(0, 6000)) - 3000;
            6, 7: r.down_velocity = $urandom;
            default: r.down_velocity = extreme_word();
        endcase
        return r;
    endfunction

    // mostly the command that moves the mode machine on, with some noise
    function automatic cmd_t next_command();
        cmd_t c;
        case (sb.mode_q)
            MODE_INIT:  c = CMD_CALIBRATE;
            MODE_CALIB: c = CMD_CALIB_DONE;
            MODE_READY:
                if ($urandom_range(1) != 0) c = CMD_ARMED;
                else c = CMD_FORCE_START;
            default:    c = CMD_TICK;
        endcase
        if ($urandom_range(99) < ((sb.mode_q == MODE_ACTIVE) ? 8 : 20))
            c = cmd_t'($urandom_range(7));
        // end is only left by reset, so landing waits for the close of the run
        if (c == CMD_LANDED && sb.mode_q == MODE_ACTIVE)
            c = CMD_FORCE_STOP;
        return c;
    endfunction

    task automatic send_request(input nav_req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_bus  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending_decisions.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        sb.set_config(index, value);
        @(negedge clk);
    endtask

    task automatic configure(input cfg_t setting);
        drain_results();
        write_reg(CFG_MAG_DECIMATE, 32'(setting.mag_decimate));
        write_reg(CFG_GPS_ACCEL_LIMIT, setting.gps_accel_limit_sq);
        write_reg(CFG_ONE_G_LOW, setting.one_g_low_sq);
        write_reg(CFG_ONE_G_HIGH, setting.one_g_high_sq);
        write_reg(CFG_ONE_G_SAMPLES, 32'(setting.one_g_samples));
        write_reg(CFG_PITOT_ALT_LIMIT, setting.pitot_alt_limit);
        write_reg(CFG_PITOT_SPEED_LIMIT, setting.pitot_speed_limit);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_traffic(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_request(random_request(next_command()));
    endtask

    initial
    begin
        nav_req_t r;
        cfg_t     setting;
        cmd_t     first_walk [11];
        cmd_t     second_walk [7];
        cmd_t     closing [5];

        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_bus       = '0;
        send_idle_pct = 12;
        recv_idle_pct = 78;
        hold_off_req  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // mode walk under reset settings, with events each mode ignores
        first_walk = '{CMD_TICK, CMD_LANDED, CMD_ARMED, CMD_CALIBRATE, CMD_FORCE_START,
                       CMD_CALIB_DONE, CMD_TICK, CMD_DISARMED, CMD_CALIBRATE,
                       CMD_CALIB_DONE, CMD_FORCE_START};
        foreach (first_walk[i]) send_request(random_request(first_walk[i]));

        // field extremes while active
        send_request(quiet_tick('0));
        r = quiet_tick({TIME_BITS{1'b1}});
        r.accel_norm_sq    = '1;
        r.gps_fix_3d       = 1'b1;
        r.dynamic_pressure = 32'h7FFF_FFFF;
        r.down_position    = 32'h7FFF_FFFF;
        r.down_velocity    = 32'h8000_0000;
        send_request(r);
        r.dynamic_pressure = 32'sd1;
        send_request(r);
        r = quiet_tick(time_t'(1));
        r.dynamic_pressure = 32'h8000_0000;
        r.down_position    = 32'h8000_0000;
        r.down_velocity    = 32'h7FFF_FFFF;
        send_request(r);
        r = quiet_tick(time_t'(2));
        r.gps_fix_3d       = 1'b1;
        r.dynamic_pressure = 32'sd1;
        r.down_position    = 32'sd1;
        r.down_velocity    = -32'sd1;
        send_request(r);

        second_walk = '{CMD_CALIBRATE, CMD_CALIB_DONE, CMD_ARMED, CMD_DISARMED, CMD_ARMED,
                        CMD_FORCE_STOP, CMD_FORCE_START};
        foreach (second_walk[i]) send_request(random_request(second_walk[i]));

        // typical flight settings
        setting = '{8'd3, 32'd100_000, 32'd60_000, 32'd72_000, 16'd3, 32'sd256_000, 32'sd1280};
        configure(setting);
        run_traffic(500);

        // wide open settings, sender slow and receiver quick
        send_idle_pct = 78;
        recv_idle_pct = 12;
        setting = '{8'd255, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'd0, 32'h7FFF_FFFF,
                    32'h8000_0000};
        configure(setting);
        run_traffic(250);
        drain_results();
        run_traffic(250);

        // closed settings, full rate, with a long result stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        setting = '{8'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        configure(setting);
        run_traffic(60);
        hold_off_req = 1'b1;
        run_traffic(140);

        setting.mag_decimate       = 8'($urandom_range(0, 6));
        setting.gps_accel_limit_sq = $urandom_range(60_000, 90_000);
        setting.one_g_low_sq       = $urandom_range(55_000, 65_000);
        setting.one_g_high_sq      = setting.one_g_low_sq + $urandom_range(2, 12_000);
        setting.one_g_samples      = 16'($urandom_range(0, 8));
        setting.pitot_alt_limit    = $urandom_range(0, 400_000);
        setting.pitot_speed_limit  = int'($urandom_range(0, 3000)) - 1500;
        configure(setting);
        run_traffic(350);

        // land, then nothing but reset may move the mode
        while (sb.mode_q != MODE_ACTIVE)
            send_request(random_request(next_command()));
        send_request(random_request(CMD_LANDED));
        closing = '{CMD_TICK, CMD_CALIBRATE, CMD_FORCE_START, CMD_DISARMED, CMD_LANDED};
        foreach (closing[i]) send_request(random_request(closing[i]));

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nug_pkg.sv
rtl/nug_mode_fsm.sv
rtl/nug_gate.sv
rtl/nav_update_gate_fsm.sv
tb/sv/nug_tb_pkg.sv
tb/sv/tb_nav_update_gate_fsm.sv
